>>> hw/rtl/oahl_pkg.sv
// Shared constants, codes and control structs for the open-address hash lookup.
// No dependencies; every other file of the block uses this package.
package oahl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int CFG_W       = 11;
    localparam int SLOT_W      = 10;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int DIV_W       = KEY_W + 1;
    localparam int CNT_W       = $clog2(DIV_W);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_WRITE = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS  = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    in_rdy;
        logic    clr_wr;
        logic    mod_key;
        logic    step;
        logic    ld_index;
        logic    set_res;
        t_status res_st;
        logic    load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic req_write;
        logic clr_last;
        logic key_zero;
        logic size_zero;
        logic mod_done;
        logic key_match;
        logic key_empty;
        logic val_zero;
        logic at_limit;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/oahl_ifs.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on oahl_pkg for the payload widths.
interface oahl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [oahl_pkg::SLOT_W-1:0] slot;
    logic [oahl_pkg::KEY_W-1:0]  key;
    logic [oahl_pkg::VAL_W-1:0]  value;

    modport source (output valid, output req_type, output slot, output key, output value,
                    input ready);
    modport sink   (input valid, input req_type, input slot, input key, input value,
                    output ready);
endinterface

interface oahl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [oahl_pkg::VAL_W-1:0]  found_value;
    logic [oahl_pkg::SLOT_W-1:0] found_slot;

    modport source (output valid, output status, output found_value, output found_slot,
                    input ready);
    modport sink   (input valid, input status, input found_value, input found_slot,
                    output ready);
endinterface

>>> hw/rtl/oahl_mod.sv
// Iterative remainder unit: dividend mod divisor, one quotient bit per cycle,
// with a short path when the dividend is below twice the divisor. Uses oahl_pkg.
module oahl_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [oahl_pkg::DIV_W-1:0]  i_dividend,
    input  logic [oahl_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [oahl_pkg::SIZE_W-1:0] o_rem
);
    import oahl_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_q, n_q;
    logic [SIZE_W-1:0] r_rem, n_rem;

    logic [DIV_W-1:0]  div_ext;
    logic [DIV_W-1:0]  div_dbl;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   trial_sub;

    assign div_ext   = DIV_W'(i_divisor);
    assign div_dbl   = div_ext << 1;
    assign trial     = {r_rem, r_q[DIV_W-1]};
    assign trial_sub = trial - {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            if (i_dividend < div_ext) begin
                n_rem  = SIZE_W'(i_dividend);
                n_done = 1'b1;
            end else if (i_dividend < div_dbl) begin
                n_rem  = SIZE_W'(i_dividend - div_ext);
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_q    = i_dividend;
                n_rem  = '0;
                n_cnt  = CNT_W'(DIV_W - 1);
            end
        end else if (r_busy) begin
            // restoring step: bring down one bit, subtract where it fits
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = SIZE_W'(trial_sub);
            end else begin
                n_rem = SIZE_W'(trial);
            end
            n_q = r_q << 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("remainder unit restarted while busy");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_divisor)) else $error("remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(i_start)) else $error("done held without a start");

endmodule

>>> hw/rtl/oahl_datapath.sv
// Datapath: key and value memories, clearing counter, probe registers,
// size register, result and output registers. Uses oahl_pkg, oahl_ifs, oahl_mod.
module oahl_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  oahl_pkg::t_cmd             i_cmd,
    output oahl_pkg::t_sts             o_sts,
    input  logic                       i_cfg_we,
    input  logic [oahl_pkg::CFG_W-1:0] i_cfg_data,
    oahl_req_if.sink                   i_req,
    oahl_rsp_if.source                 o_rsp
);
    import oahl_pkg::*;

    logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]  val_mem [TABLE_DEPTH];

    logic [CFG_W-1:0]  r_table_size;
    logic [IDX_W-1:0]  r_clr_addr;
    logic [SIZE_W-1:0] r_size;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_probe;
    logic [IDX_W-1:0]  r_index;
    logic [SIZE_W-1:0] r_reads;
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;
    logic [1:0]        r_res_status;
    logic [VAL_W-1:0]  r_res_value;
    logic [SLOT_W-1:0] r_res_slot;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [VAL_W-1:0]  r_out_value;
    logic [SLOT_W-1:0] r_out_slot;

    logic              accept;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [KEY_W-1:0]  mem_wk;
    logic [VAL_W-1:0]  mem_wv;
    logic [SIZE_W-1:0] size_eff;
    logic [KEY_W-1:0]  probe_nx;
    logic              mod_start;
    logic [DIV_W-1:0]  mod_dividend;
    logic              mod_done;
    logic [SIZE_W-1:0] mod_rem;

    assign i_req.ready = i_cmd.in_rdy;
    assign accept      = i_req.valid && i_cmd.in_rdy;

    // saturate the size register to the table depth
    assign size_eff = (32'(r_table_size) > 32'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH)
                                                             : SIZE_W'(r_table_size);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_addr;
        mem_wk = '0;
        mem_wv = '0;
        if (i_cmd.clr_wr) begin
            mem_we = 1'b1;
        end else if (accept && (i_req.req_type == REQ_WRITE)) begin
            mem_we = (32'(i_req.slot) < 32'(TABLE_DEPTH));
            mem_wa = IDX_W'(i_req.slot);
            mem_wk = i_req.key;
            mem_wv = i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[mem_wa] <= mem_wk;
            val_mem[mem_wa] <= mem_wv;
        end
        if (i_cmd.ld_index) begin
            r_rd_key <= key_mem[mod_rem[IDX_W-1:0]];
            r_rd_val <= val_mem[mod_rem[IDX_W-1:0]];
        end
    end

    assign probe_nx     = {1'b0, r_probe[KEY_W-1:1]} + KEY_W'(1);
    assign mod_start    = i_cmd.mod_key || i_cmd.step;
    assign mod_dividend = i_cmd.step ? (DIV_W'(r_index) + DIV_W'(probe_nx))
                                     : {1'b0, r_key};

    oahl_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (r_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key   <= i_req.key;
            r_probe <= i_req.key;
            r_size  <= size_eff;
            r_reads <= SIZE_W'(1);
        end
        if (i_cmd.step) begin
            r_probe <= probe_nx;
            r_reads <= r_reads + SIZE_W'(1);
        end
        if (i_cmd.ld_index) begin
            r_index <= mod_rem[IDX_W-1:0];
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_st;
            if (i_cmd.res_st == ST_FOUND) begin
                r_res_value <= r_rd_val;
                r_res_slot  <= SLOT_W'(r_index);
            end else begin
                r_res_value <= '0;
                r_res_slot  <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_value;
    assign o_rsp.found_slot  = r_out_slot;

    always_comb begin
        o_sts.in_valid  = i_req.valid;
        o_sts.req_write = (i_req.req_type == REQ_WRITE);
        o_sts.clr_last  = (r_clr_addr == IDX_W'(TABLE_DEPTH - 1));
        o_sts.key_zero  = (r_key == '0);
        o_sts.size_zero = (r_size == '0);
        o_sts.mod_done  = mod_done;
        o_sts.key_match = (r_rd_key == r_key);
        o_sts.key_empty = (r_rd_key == '0);
        o_sts.val_zero  = (r_rd_val == '0);
        o_sts.at_limit  = (r_reads >= r_size);
        o_sts.out_free  = !r_out_valid || o_rsp.ready;
    end

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid) else $error("output not raised after load");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FOUND)) |-> (r_out_value != '0))
        else $error("found result carries a zero value");

    a_index_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_index |-> (mod_rem < r_size)) else $error("probe index beyond size");

endmodule

>>> hw/rtl/oahl_ctrl.sv
// Controller state machine: clearing pass, request decode, probe loop, result hand-off.
// Uses oahl_pkg; talks to the datapath through t_cmd and t_sts only.
module oahl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  oahl_pkg::t_sts i_sts,
    output oahl_pkg::t_cmd o_cmd
);
    import oahl_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_START = 6'b000100,
        S_MOD   = 6'b001000,
        S_CHK   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_st = ST_WRITE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.req_write) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_st  = ST_WRITE;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.key_zero || i_sts.size_zero) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_MISS;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.mod_key = 1'b1;
                    n_state       = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.ld_index = 1'b1;
                    n_state        = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.key_match) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = i_sts.val_zero ? ST_MISS : ST_FOUND;
                    n_state       = S_DONE;
                end else if (i_sts.key_empty) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_MISS;
                    n_state       = S_DONE;
                end else if (i_sts.at_limit) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_LIMIT;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/open_address_hash_lookup.sv
// Top level of the open-address hash lookup: controller plus datapath.
// Depends on oahl_pkg, oahl_ifs, oahl_ctrl and oahl_datapath.
//
//  channel  | dir | beat contents                          | handshake
//  ---------+-----+----------------------------------------+-------------
//  i_req    | in  | req_type, slot, key, value             | valid/ready
//  o_rsp    | out | status, found_value, found_slot        | valid/ready
//  cfg      | in  | i_cfg_data (table_size)                | i_cfg_we
//
//  A write beat's result is set when the beat is taken and offered once the output
//  register is free; a zero key or zero size gives a miss with no slot read.
//  Otherwise the first slot is the key's remainder by the size, worked out one bit
//  per cycle, with a short path when the key is below twice the size; each further
//  probe reads the remainder of index+probe, with the same short path, and the
//  result is registered after the deciding read. One beat is worked on at a time.
//  After reset the key and value memories are swept to zero, one slot a cycle,
//  over all TABLE_DEPTH (1024) slots; no request beat is taken until it ends.
//  The result sits in an output register, so a stalled response holds there
//  while the next request beat is already taken and processed.
module open_address_hash_lookup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    oahl_req_if.sink                   i_req,
    oahl_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [oahl_pkg::CFG_W-1:0] i_cfg_data
);
    import oahl_pkg::*;

    // commands down, status up: the only link between the two halves
    t_cmd cmd;
    t_sts sts;

    oahl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // memories, probe arithmetic, remainder unit and the output register
    oahl_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_rsp      (o_rsp)
    );

endmodule

>>> bench/open_address_hash_lookup_test.sv
// Self-checking testbench for open_address_hash_lookup: slot writes and probed key lookups.
// Depends on oahl_pkg, the oahl_req_if / oahl_rsp_if interfaces and the block's RTL.
// A scoreboard class mirrors the key/value store and predicts every response beat.
module open_address_hash_lookup_test;
    import oahl_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASE_ITEMS = 48;
    localparam int N_PHASES = 13;
    // Table sizes per random phase: tiny tables that fill up, full depth, oversized, zero
    localparam int unsigned PHASE_SIZES [N_PHASES] =
        '{7, 2, 61, 1, 1024, 3, 16, 2047, 256, 1000, 1500, 0, 5};

    typedef struct {
        logic              req_type;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_hash_req;

    typedef struct {
        t_status           status;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
    } t_lookup_result;

    // Mirror of the slot store and the size register; holds the responses still owed
    class t_lookup_scoreboard;
        logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
        logic [VAL_W-1:0] val_mem [TABLE_DEPTH];
        logic [CFG_W-1:0] size_reg;
        t_lookup_result   pending_results [$];
        int               errors;

        function new();
            foreach (key_mem[i]) begin
                key_mem[i] = '0;
                val_mem[i] = '0;
            end
            size_reg = '0;
            errors = 0;
        endfunction

        function void set_table_size(logic [CFG_W-1:0] v);
            size_reg = v;
        endfunction

        // Saturate the register to the store depth
        function int unsigned active_size();
            return (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Walk the probe chain of a key; stop on the key, an empty slot or the read limit
        function t_lookup_result predict_lookup(logic [KEY_W-1:0] key);
            t_lookup_result  res;
            int unsigned     span;
            int unsigned     reads;
            longint unsigned idx;
            longint unsigned probe;
            res = '{status: ST_MISS, value: '0, slot: '0};
            span = active_size();
            if (key == '0 || span == 0)
                return res;
            idx = key % span;
            probe = key;
            reads = 1;
            while (key_mem[idx] != key) begin
                if (key_mem[idx] == '0)
                    return res;
                if (reads >= span) begin
                    res.status = ST_LIMIT;
                    return res;
                end
                probe = (probe >> 1) + 1;
                idx = (idx + probe) % span;
                reads++;
            end
            // a matching slot with a zero value still counts as a miss
            if (val_mem[idx] == '0)
                return res;
            res.status = ST_FOUND;
            res.value = val_mem[idx];
            res.slot = SLOT_W'(idx);
            return res;
        endfunction

        // Slot where a proper insert of this key lands, or -1 for a zero key or size or a full chain
        function int free_slot_for(logic [KEY_W-1:0] key);
            int unsigned     span;
            int unsigned     reads;
            longint unsigned idx;
            longint unsigned probe;
            span = active_size();
            if (key == '0 || span == 0)
                return -1;
            idx = key % span;
            probe = key;
            for (reads = 1; reads <= span; reads++) begin
                if (key_mem[idx] == '0 || key_mem[idx] == key)
                    return int'(idx);
                probe = (probe >> 1) + 1;
                idx = (idx + probe) % span;
            end
            return -1;
        endfunction

        function void note_request(t_hash_req r);
            t_lookup_result res;
            if (r.req_type == REQ_WRITE) begin
                key_mem[r.slot] = r.key;
                val_mem[r.slot] = r.value;
                res = '{status: ST_WRITE, value: '0, slot: '0};
            end else begin
                res = predict_lookup(r.key);
            end
            pending_results = {pending_results, res};
        endfunction

        function void check_result(logic [1:0] st, logic [VAL_W-1:0] v, logic [SLOT_W-1:0] s);
            t_lookup_result want;
            if (pending_results.size() == 0) begin
                $error("response beat with no request outstanding: status %0d", st);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (v !== want.value) begin
                $error("found_value: expected 0x%08h, got 0x%08h", want.value, v);
                errors++;
            end
            if (s !== want.slot) begin
                $error("found_slot: expected %0d, got %0d", want.slot, s);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    oahl_req_if req_if();
    oahl_rsp_if rsp_if();

    t_lookup_scoreboard sb;
    logic [KEY_W-1:0] known_keys [$];
    bit               idle_on;
    int               hold_asks;
    int               hold_served;
    int               hold_left;
    int               stall_left;

    open_address_hash_lookup i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Response side: drive ready at the rising edge. A long hold asked for by the
    // stimulus is counted down here, otherwise, in idle phases, drop ready in short random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Sample mid-cycle: valid, ready and payload are settled for the coming edge
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result(rsp_if.status, rsp_if.found_value, rsp_if.found_slot);
    end

    // Offer one request beat and hold it until taken; note it at the accepting edge.
    // Enter and leave at a rising edge, so valid gets one update per step.
    task automatic send_beat(t_hash_req r);
        logic taken;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= r.req_type;
        req_if.slot     <= r.slot;
        req_if.key      <= r.key;
        req_if.value    <= r.value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (req_if.ready === 1'b1);
            @(posedge i_clk);
        end
        sb.note_request(r);
    endtask

    task automatic write_slot(logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] value);
        t_hash_req r;
        r = '{req_type: REQ_WRITE, slot: slot, key: key, value: value};
        send_beat(r);
    endtask

    // Lookup beats carry random slot and value bits, which the block must ignore
    task automatic lookup_key(logic [KEY_W-1:0] key);
        t_hash_req r;
        r = '{req_type: REQ_LOOKUP, slot: SLOT_W'($urandom), key: key, value: $urandom};
        send_beat(r);
    endtask

    // Drop valid and wait until every owed response has come back, then settle
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_table_size(logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_table_size(v);
    endtask

    // One random phase at the current size: mostly proper inserts along the probe
    // chain and lookups of stored keys, the rest misses, zero keys, deletes and
    // raw writes anywhere in the store.
    task automatic run_phase(int unsigned items, bit keep_idle);
        int unsigned      pick;
        int unsigned      span;
        int unsigned      home;
        int               free;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0] value;
        idle_on = keep_idle;
        span = sb.active_size();
        home = (span == 0) ? 0 : $urandom_range(0, span - 1);
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // colliding keys share a home slot and force long probe chains
                if (span != 0 && $urandom_range(0, 1) == 1)
                    key = $urandom_range(1, 8) * span + home;
                else
                    key = $urandom;
                free = sb.free_slot_for(key);
                if (free >= 0)
                    slot = SLOT_W'(free);
                else if (span != 0)
                    slot = SLOT_W'($urandom_range(0, span - 1));
                else
                    slot = SLOT_W'($urandom);
                value = ($urandom_range(0, 19) == 0) ? '0 : VAL_W'($urandom);
                known_keys = {known_keys, key};
                write_slot(slot, key, value);
            end else if (pick < 70) begin
                if (known_keys.size() != 0)
                    lookup_key(known_keys[$urandom_range(0, known_keys.size() - 1)]);
                else
                    lookup_key($urandom);
            end else if (pick < 80) begin
                lookup_key($urandom);
            end else if (pick < 84) begin
                lookup_key('0);
            end else if (pick < 90) begin
                // delete: a zero key empties the slot
                slot = (span != 0) ? SLOT_W'($urandom_range(0, span - 1)) : SLOT_W'($urandom);
                write_slot(slot, '0, $urandom);
            end else begin
                write_slot(SLOT_W'($urandom), $urandom, $urandom);
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_WRITE;
        req_if.slot     = '0;
        req_if.key      = '0;
        req_if.value    = '0;
        rsp_if.ready    = 1'b0;
        idle_on         = 1'b0;
        hold_asks       = 0;
        hold_served     = 0;
        hold_left       = 0;
        stall_left      = 0;
        sb = new();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Zero size: every lookup misses, writes still land.
        set_table_size('0);
        lookup_key(32'h1234_5678);
        write_slot(SLOT_W'(TABLE_DEPTH - 1), 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        write_slot('0, 32'd4, 32'hFFFF_FFFF);
        wait_idle();

        // Four slots: direct hit, empty slot after one probe, zero value,
        // then a full table that runs into the probe limit.
        set_table_size(CFG_W'(4));
        lookup_key('0);
        lookup_key(32'd4);
        lookup_key(32'd12);
        write_slot(SLOT_W'(1), 32'd8, '0);
        lookup_key(32'd8);
        write_slot(SLOT_W'(2), 32'h8000_0001, 32'd1);
        write_slot(SLOT_W'(3), 32'h7FFF_FFFF, 32'h8000_0000);
        lookup_key(32'd16);
        lookup_key(32'h8000_0001);
        write_slot(SLOT_W'(2), '0, 32'h5555_5555);
        lookup_key(32'd16);
        wait_idle();

        // Oversized register saturates to the full depth: top slot reachable
        set_table_size('1);
        lookup_key(32'hFFFF_FFFF);
        lookup_key(32'h0000_0400);
        wait_idle();

        // One slot: a single read decides everything
        set_table_size(CFG_W'(1));
        lookup_key(32'd7);
        lookup_key(32'd4);
        write_slot('0, '0, '0);
        lookup_key(32'd4);
        wait_idle();

        // Random phases; idle in most, none in the closing ones
        for (int p = 0; p < N_PHASES; p++) begin
            set_table_size(CFG_W'(PHASE_SIZES[p]));
            known_keys.delete();
            // stall the response side for a long stretch while beats keep coming
            if (p == 2)
                hold_asks++;
            run_phase(PHASE_ITEMS, (p < N_PHASES - 2) && (p % 4 != 3));
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d responses never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, clearing sweep included
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> open_address_hash_lookup.f
hw/rtl/oahl_pkg.sv
hw/rtl/oahl_ifs.sv
hw/rtl/oahl_mod.sv
hw/rtl/oahl_datapath.sv
hw/rtl/oahl_ctrl.sv
hw/rtl/open_address_hash_lookup.sv
bench/open_address_hash_lookup_test.sv
